// ===== rtl/pfss_pkg.sv =====
// ----------------------------------------------------------------------------
// pfss_pkg
// shared types and constants of the frame sync word search
// ----------------------------------------------------------------------------
package pfss_pkg;

  localparam int PATTERN_W   = 24;
  localparam int LIMIT_W     = 5;
  localparam int OFFSET_W    = 19;
  localparam int CFG_INDEX_W = 4;

  localparam logic [PATTERN_W-1:0] PATTERN_RESET = 24'hFAF320;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 5'd1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_PATTERN = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_LIMIT  = 4'd1;

  typedef struct packed {
    logic       hit;
    logic [2:0] sel;
  } pfss_match_t;

endpackage

// ===== rtl/pcm_frame_sync_search_core.sv =====
// ----------------------------------------------------------------------------
// pcm_frame_sync_search_core
// pipeline: two register stages, an accepted byte goes through the input
// register, then the window compare into the result register
// throughput: one byte per cycle (single window compare stage) unless out_ready stalls
// reset: synchronous, clears valids and buffer state, loads sync pattern
// 0xFAF320 and error limit 1
// ----------------------------------------------------------------------------
module pcm_frame_sync_search_core #(
  parameter int MAX_BYTES = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic [pfss_pkg::OFFSET_W-1:0]    bit_offset,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfss_pkg::PATTERN_W-1:0]   cfg_data
);
  import pfss_pkg::*;

  localparam int IDX_W = $clog2(MAX_BYTES + 1);
  localparam int OFF_W = IDX_W + 3;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BYTES);

  logic [PATTERN_W-1:0] sync_pattern;
  logic [LIMIT_W-1:0]   error_limit;

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       adv;
  logic       s1_fire;

  logic [PATTERN_W-1:0] window_bytes, window_bytes_next;
  logic [IDX_W-1:0]     byte_index, byte_index_next;
  logic                 search_done, search_done_next;

  logic                 in_range;
  pfss_match_t          match;
  logic [OFF_W-1:0]     off_full;
  logic [OFF_W+OFFSET_W-1:0] off_ext;

  logic                 out_valid_next;
  logic                 found_next;
  logic [OFFSET_W-1:0]  bit_offset_next;
  logic                 produce;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= PATTERN_RESET;
      error_limit  <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_PATTERN: sync_pattern <= cfg_data;
        CFG_ERROR_LIMIT:  error_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign adv      = !out_valid || out_ready;
  assign s1_fire  = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  // window compare
  assign in_range = byte_index < MAX_IDX;

  pfss_match u_match (
    .window_bytes (window_bytes),
    .data_byte    (s1_data),
    .sync_pattern (sync_pattern),
    .error_limit  (error_limit),
    .enable       (in_range && (byte_index >= IDX_W'(3))),
    .result       (match)
  );

  assign off_full = {byte_index - IDX_W'(3), match.sel};
  assign off_ext  = {{OFFSET_W{1'b0}}, off_full};

  always_comb begin
    window_bytes_next = window_bytes;
    byte_index_next   = byte_index;
    search_done_next  = search_done;
    produce           = 1'b0;
    found_next        = 1'b0;
    bit_offset_next   = '0;
    if (s1_fire) begin
      if (search_done) begin
        if (s1_last) begin
          window_bytes_next = '0;
          byte_index_next   = '0;
          search_done_next  = 1'b0;
        end
      end else begin
        if (in_range) begin
          window_bytes_next = {window_bytes[15:0], s1_data};
          byte_index_next   = byte_index + IDX_W'(1);
        end
        if (match.hit) begin
          produce          = 1'b1;
          found_next       = 1'b1;
          bit_offset_next  = off_ext[OFFSET_W-1:0];
          search_done_next = 1'b1;
        end else if (s1_last) begin
          produce = 1'b1;
        end
        if (s1_last) begin
          window_bytes_next = '0;
          byte_index_next   = '0;
          search_done_next  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes <= '0;
      byte_index   <= '0;
      search_done  <= 1'b0;
    end else begin
      window_bytes <= window_bytes_next;
      byte_index   <= byte_index_next;
      search_done  <= search_done_next;
    end
  end

  // result register
  always_comb begin
    out_valid_next = out_valid;
    if (s1_fire) begin
      out_valid_next = produce;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      found      <= found_next;
      bit_offset <= bit_offset_next;
    end
  end

  a_nofind_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> bit_offset == '0)
    else $error("not-found result with non-zero offset");

  a_done_index : assert property (@(posedge clk) disable iff (rst)
    search_done |-> byte_index >= IDX_W'(4))
    else $error("search done before a full window");

  a_index_sat : assert property (@(posedge clk) disable iff (rst)
    byte_index <= MAX_IDX)
    else $error("byte index beyond saturation");

  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> byte_index == '0 && !search_done && window_bytes == '0)
    else $error("buffer state not cleared after last byte");

endmodule

// ===== rtl/pfss_match.sv =====
// ----------------------------------------------------------------------------
// pfss_match
// eight parallel window compares with hamming distance limit, lowest
// bit offset wins
// ----------------------------------------------------------------------------
module pfss_match (
  input  logic [pfss_pkg::PATTERN_W-1:0] window_bytes,
  input  logic [7:0]                     data_byte,
  input  logic [pfss_pkg::PATTERN_W-1:0] sync_pattern,
  input  logic [pfss_pkg::LIMIT_W-1:0]   error_limit,
  input  logic                           enable,
  output pfss_pkg::pfss_match_t          result
);
  import pfss_pkg::*;

  logic [31:0]          word;
  logic [7:0]           close;
  logic [LIMIT_W-1:0]   diff_count [8];

  assign word = {window_bytes, data_byte};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      diff_count[b] = LIMIT_W'($countones(word[31-b -: PATTERN_W] ^ sync_pattern));
      close[b]      = (diff_count[b] <= error_limit);
    end
  end

  always_comb begin
    result.hit = enable && (close != 8'd0);
    result.sel = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (close[b]) begin
        result.sel = 3'(b);
      end
    end
  end

endmodule
